/* rtl/gdsd_pkg.sv */
// ----------------------------------------------------------------------------
// gdsd_pkg
// Shared widths, calendar constants, month-length and leap helpers and the request
// type of the shared adder used by the date subtraction core.
// ----------------------------------------------------------------------------
package gdsd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int BACK_W  = 16;

    // Running day count: must hold day_in - days_back down to -65534.
    localparam int ACC_W   = BACK_W + 2;

    // year mod 25 residue, together with the low year bits, settles the leap rule.
    localparam int CENT_DIV = 25;
    localparam int RES_W    = 5;

    // year / 25 equals (year * CENT_RECIP) >> CENT_SHIFT for every 14-bit year.
    localparam int RECIP_W    = 15;
    localparam int CENT_SHIFT = 19;
    localparam int PROD_W     = YEAR_W + RECIP_W;
    localparam int QUOT_W     = PROD_W - CENT_SHIFT;
    localparam logic [RECIP_W-1:0] CENT_RECIP = RECIP_W'(20972);

    localparam logic [YEAR_W-1:0]  MIN_YEAR = YEAR_W'(1601);
    localparam logic [MONTH_W-1:0] MON_JAN  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MON_FEB  = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MON_APR  = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] MON_JUN  = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] MON_SEP  = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] MON_NOV  = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] MON_DEC  = MONTH_W'(12);

    // Request to the shared adder/subtractor.
    typedef struct packed {
        logic                    sub;
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] b;
    } alu_req_t;

    // Length of a month; codes outside 1..12 are screened out before use.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                MON_FEB:  len = leap ? DAY_W'(29) : DAY_W'(28);
                MON_APR,
                MON_JUN,
                MON_SEP,
                MON_NOV:  len = DAY_W'(30);
                default:  len = DAY_W'(31);
            endcase
            return len;
        end
    endfunction

    // Leap test from the year's low bits and its residue mod 25:
    // divisible by 100 means divisible by 4 with residue 0, and
    // divisible by 400 means divisible by 16 with residue 0.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                     input logic [RES_W-1:0] r25);
        begin
            return ((y[1:0] == 2'b00) && (r25 != '0)) ||
                   ((y[3:0] == 4'b0000) && (r25 == '0));
        end
    endfunction

endpackage

/* rtl/gdsd_alu.sv */
// ----------------------------------------------------------------------------
// gdsd_alu
// Shared signed adder/subtractor used for the year residue, the initial
// subtraction and every month step of the walk.
// ----------------------------------------------------------------------------
module gdsd_alu
(
    input  gdsd_pkg::alu_req_t                req,
    output logic signed [gdsd_pkg::ACC_W-1:0] res
);

    assign res = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

/* rtl/gregorian_date_subtract_days_core.sv */
// ----------------------------------------------------------------------------
// gregorian_date_subtract_days_core
// Validates a Gregorian date and subtracts a day count from it, one month
// per step, using a single shared adder under a small sequencer.
// ----------------------------------------------------------------------------
// One request is processed at a time and s_tready stays low while it runs.
// A request passes through intake, the residue step, the date check, the
// month walk and the output load: the year's quotient by 25 is taken at
// intake by a scaled reciprocal multiply, the residue step turns it into the
// residue mod 25 for the leap rule, and the month walk advances one month
// per cycle through the shared adder. An invalid date skips the walk and
// answers with tuser low and all date fields zero. The finished result sits
// in an output register, so a new request is accepted as soon as the result
// is loaded there.
// ----------------------------------------------------------------------------
module gregorian_date_subtract_days_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // day_in[4:0], month_in[8:5], year_in[22:9],
                                  // days_back[38:23], zero pad [39]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // day_out[4:0], month_out[8:5],
                                  // year_out[22:9], zero pad [23]
    output logic [0:0]  m_tuser   // date_valid[0]
);

    localparam int DW   = gdsd_pkg::DAY_W;
    localparam int MW   = gdsd_pkg::MONTH_W;
    localparam int YW   = gdsd_pkg::YEAR_W;
    localparam int BW   = gdsd_pkg::BACK_W;
    localparam int AW   = gdsd_pkg::ACC_W;
    localparam int RW   = gdsd_pkg::RES_W;
    localparam int PW   = gdsd_pkg::PROD_W;
    localparam int QW   = gdsd_pkg::QUOT_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MOD   = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic            m_valid_reg, m_valid_next;

    logic [DW-1:0]   day_reg, day_next;
    logic [MW-1:0]   month_reg, month_next;
    logic [YW-1:0]   year_reg, year_next;
    logic [BW-1:0]   back_reg, back_next;
    logic [QW-1:0]   quot_reg, quot_next;
    logic [RW-1:0]   r25_reg, r25_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic            ok_reg, ok_next;

    logic [DW-1:0]   out_day_reg, out_day_next;
    logic [MW-1:0]   out_month_reg, out_month_next;
    logic [YW-1:0]   out_year_reg, out_year_next;
    logic            out_ok_reg, out_ok_next;

    gdsd_pkg::alu_req_t   alu_req;
    logic signed [AW-1:0] alu_res;

    logic            s_fire;
    logic            out_free;
    logic            leap_now;
    logic [PW-1:0]   recip_prod;
    logic [AW-1:0]   cent_mult;
    logic [DW-1:0]   cur_len;
    logic            date_ok;
    logic            acc_pos;
    logic [MW-1:0]   prev_month;
    logic [DW-1:0]   step_len;

    gdsd_alu u_alu
    (
        .req (alu_req),
        .res (alu_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign leap_now   = gdsd_pkg::is_leap(year_reg, r25_reg);
    assign recip_prod = PW'(s_tdata[22:9]) * PW'(gdsd_pkg::CENT_RECIP);
    assign cent_mult  = AW'(quot_reg) * AW'(gdsd_pkg::CENT_DIV);
    assign cur_len    = gdsd_pkg::month_days(month_reg, leap_now);
    assign date_ok    = (year_reg >= gdsd_pkg::MIN_YEAR) &&
                        (month_reg >= gdsd_pkg::MON_JAN) &&
                        (month_reg <= gdsd_pkg::MON_DEC) &&
                        (day_reg != '0) && (day_reg <= cur_len);
    assign acc_pos    = !acc_reg[AW-1] && (acc_reg != '0);

    // Month before the current one; December's length does not depend on leap.
    assign prev_month = (month_reg == gdsd_pkg::MON_JAN) ? gdsd_pkg::MON_DEC
                                                         : month_reg - MW'(1);
    assign step_len   = gdsd_pkg::month_days(prev_month, leap_now);

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_req.sub = 1'b1;
        alu_req.a   = AW'(year_reg);
        alu_req.b   = cent_mult;
        case (state_reg)
            ST_CHECK:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = AW'(day_reg);
                alu_req.b   = AW'(back_reg);
            end
            ST_WALK:
            begin
                alu_req.sub = 1'b0;
                alu_req.a   = acc_reg;
                alu_req.b   = AW'(step_len);
            end
            default:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = AW'(year_reg);
                alu_req.b   = cent_mult;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        back_next      = back_reg;
        quot_next      = quot_reg;
        r25_next       = r25_reg;
        acc_next       = acc_reg;
        ok_next        = ok_reg;
        out_day_next   = out_day_reg;
        out_month_next = out_month_reg;
        out_year_next  = out_year_reg;
        out_ok_next    = out_ok_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    day_next   = s_tdata[4:0];
                    month_next = s_tdata[8:5];
                    year_next  = s_tdata[22:9];
                    back_next  = s_tdata[38:23];
                    quot_next  = recip_prod[PW-1:gdsd_pkg::CENT_SHIFT];
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                // The year minus 25 times its quotient leaves 0..24.
                r25_next   = alu_res[RW-1:0];
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                ok_next  = date_ok;
                acc_next = alu_res;
                if (date_ok)
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WALK:
            begin
                if (acc_pos)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    acc_next   = alu_res;
                    month_next = prev_month;
                    if (month_reg == gdsd_pkg::MON_JAN)
                    begin
                        year_next = year_reg - YW'(1);
                        r25_next  = (r25_reg == '0) ? RW'(gdsd_pkg::CENT_DIV - 1)
                                                    : r25_reg - RW'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_ok_next    = ok_reg;
                    out_day_next   = ok_reg ? acc_reg[DW-1:0] : '0;
                    out_month_next = ok_reg ? month_reg : '0;
                    out_year_next  = ok_reg ? year_reg : '0;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg       <= day_next;
        month_reg     <= month_next;
        year_reg      <= year_next;
        back_reg      <= back_next;
        quot_reg      <= quot_next;
        r25_reg       <= r25_next;
        acc_reg       <= acc_next;
        ok_reg        <= ok_next;
        out_day_reg   <= out_day_next;
        out_month_reg <= out_month_next;
        out_year_reg  <= out_year_next;
        out_ok_reg    <= out_ok_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_year_reg, out_month_reg, out_day_reg};
    assign m_tuser  = out_ok_reg;

endmodule

/* rtl/gdsd_checker.sv */
// ----------------------------------------------------------------------------
// gdsd_checker
// Port-level checks for the date subtraction core, attached by bind.
// ----------------------------------------------------------------------------
module gdsd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // Taking a request makes the core busy, so s_tready drops.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("core ready right after accepting a request");

    // A stalled result keeps its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // A rejected date carries only zeros.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("invalid date result is not zero");

    // A valid result has a nonzero day, a month in 1..12 and a zero pad bit.
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |->
            ((m_tdata[4:0] != 5'd0) && (m_tdata[8:5] != 4'd0) &&
             (m_tdata[8:5] <= 4'd12) && (m_tdata[23] == 1'b0)))
        else $error("valid result outside calendar range");

endmodule

bind gregorian_date_subtract_days_core gdsd_checker u_gdsd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives date requests into the date subtraction core. It covers calendar
// edges, invalid dates, a pause until all results drain and a long mixed
// random run, with random gaps on both stream sides. Each result is checked
// field by field against an in-order store of predicted dates.
// ----------------------------------------------------------------------------
module testbench;

    import gdsd_pkg::*;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [BACK_W-1:0]  back;
    } date_req_t;

    typedef struct packed {
        logic               valid;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_res_t;

    localparam int unsigned NORMAL_LEN [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};
    localparam int MAX_PRINTED = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // day_in, month_in, year_in, days_back, pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // day_out, month_out, year_out, pad
    logic [0:0]  m_tuser;        // date_valid

    date_res_t   expected_dates[$];
    date_res_t   oldest_date;
    int          mismatch_count = 0;
    int          ready_stall = 0;
    logic        steady_mode = 1'b0;

    gregorian_date_subtract_days_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    function automatic int month_length(input int m, input int y);
        int len;
        begin
            len = NORMAL_LEN[m - 1];
            if (m == int'(MON_FEB) && (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0))
                len = len + 1;
            return len;
        end
    endfunction

    // Returns zero for an invalid date, else walks back one month at a time until the running day count is positive.
    function automatic date_res_t subtract_days(input date_req_t r);
        date_res_t res;
        int d;
        int m;
        int y;
        begin
            res = '0;
            m = int'(r.month);
            y = int'(r.year);
            if (r.year < MIN_YEAR || m < int'(MON_JAN) || m > int'(MON_DEC) ||
                r.day == 0 || int'(r.day) > month_length(m, y))
                return res;
            d = int'(r.day) - int'(r.back);
            while (d < 1)
            begin
                m = m - 1;
                if (m < int'(MON_JAN))
                begin
                    m = int'(MON_DEC);
                    y = y - 1;
                end
                d = d + month_length(m, y);
            end
            res.valid = 1'b1;
            res.day   = DAY_W'(d);
            res.month = MONTH_W'(m);
            res.year  = YEAR_W'(y);
            return res;
        end
    endfunction

    function automatic date_req_t date_req(input int d, input int m, input int y,
                                           input int b);
        date_req_t r;
        begin
            r.day   = DAY_W'(d);
            r.month = MONTH_W'(m);
            r.year  = YEAR_W'(y);
            r.back  = BACK_W'(b);
            return r;
        end
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pause_len();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                return 0;
            if (r < 90)
                return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
    endfunction

    function automatic date_req_t random_valid_date();
        date_req_t r;
        int y;
        int m;
        int len;
        int sel;
        begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
                y = $urandom_range(1601, 2400);
            else if (sel < 85)
                y = $urandom_range(1601, 1700);
            else
                y = $urandom_range(2401, 16383);
            m = $urandom_range(1, 12);
            len = month_length(m, y);
            sel = $urandom_range(0, 9);
            if (sel == 0)
                r = date_req(1, m, y, 0);
            else if (sel == 1)
                r = date_req(len, m, y, 0);
            else
                r = date_req($urandom_range(1, len), m, y, 0);
            sel = $urandom_range(0, 99);
            if (sel < 60)
                r.back = BACK_W'($urandom_range(0, 400));
            else if (sel < 85)
                r.back = BACK_W'($urandom_range(0, 3000));
            else if (sel < 95)
                r.back = BACK_W'($urandom_range(3000, 20000));
            else
                r.back = BACK_W'($urandom_range(0, 65535));
            return r;
        end
    endfunction

    // A well-formed date with one field broken, or plain noise.
    function automatic date_req_t random_bad_date();
        date_req_t r;
        int len;
        begin
            r = random_valid_date();
            len = month_length(int'(r.month), int'(r.year));
            case ($urandom_range(0, 4))
                0: r.day = (len < 31) ? DAY_W'(len + 1) : DAY_W'(0);
                1: r.month = $urandom_range(0, 1) ? MONTH_W'(0)
                                                  : MONTH_W'($urandom_range(13, 15));
                2: r.year = YEAR_W'($urandom_range(0, 1600));
                default:
                    r = date_req($urandom_range(0, 31), $urandom_range(0, 15),
                                 $urandom_range(0, 16383), $urandom_range(0, 65535));
            endcase
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTED)
                $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        end
    endtask

    // Holds the request until it is accepted, then leaves a random gap unless in steady mode.
    task automatic send_date(input date_req_t r);
        int gap;
        begin
            s_tdata  <= {1'b0, r.back, r.year, r.month, r.day};
            s_tvalid <= 1'b1;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            expected_dates.push_back(subtract_days(r));
            gap = steady_mode ? 0 : pause_len();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_results_drained();
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (expected_dates.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic test_calendar_edges();
        begin
            send_date(date_req(1, 3, 2000, 1));       // century leap year
            send_date(date_req(1, 3, 1900, 1));       // century, not leap
            send_date(date_req(1, 3, 2100, 1));
            send_date(date_req(1, 3, 2004, 1));
            send_date(date_req(29, 2, 2024, 0));
            send_date(date_req(1, 1, 1601, 0));
            send_date(date_req(1, 1, 1601, 1));       // steps below the first valid year
            send_date(date_req(1, 1, 1601, 65535));
            send_date(date_req(31, 12, 16383, 0));
            send_date(date_req(31, 12, 16383, 65535));
            send_date(date_req(31, 12, 9999, 365));
            send_date(date_req(15, 8, 2023, 31));
        end
    endtask

    task automatic test_invalid_dates();
        begin
            send_date(date_req(29, 2, 2023, 5));
            send_date(date_req(30, 2, 2000, 0));
            send_date(date_req(31, 4, 2020, 0));
            send_date(date_req(0, 6, 2020, 10));
            send_date(date_req(10, 0, 2020, 10));
            send_date(date_req(10, 13, 2020, 10));
            send_date(date_req(31, 15, 16383, 65535));
            send_date(date_req(31, 12, 1600, 1));
            send_date(date_req(0, 0, 0, 0));
        end
    endtask

    // The sender stops until the core has answered everything it took.
    task automatic test_drain_pause();
        begin
            repeat (6) send_date(random_valid_date());
            wait_results_drained();
            repeat (6) send_date(random_valid_date());
        end
    endtask

    task automatic test_random_dates(input int count);
        begin
            for (int i = 0; i < count; i++)
            begin
                if (i == count / 3)
                    steady_mode <= 1'b1;
                if (i == count / 3 + 30)
                    steady_mode <= 1'b0;
                if ($urandom_range(0, 99) < 85)
                    send_date(random_valid_date());
                else
                    send_date(random_bad_date());
            end
        end
    endtask

    // Result side: random stalls, except during the steady stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            ready_stall <= 0;
        end
        else if (steady_mode)
            m_tready <= 1'b1;
        else if (ready_stall > 0)
        begin
            m_tready    <= 1'b0;
            ready_stall <= ready_stall - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                ready_stall <= pause_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_dates.size() == 0)
                report_mismatch("result with no request pending", int'(m_tdata), 0);
            else
            begin
                oldest_date = expected_dates.pop_front();
                if (m_tuser[0] !== oldest_date.valid)
                    report_mismatch("date_valid", int'(m_tuser[0]), int'(oldest_date.valid));
                if (m_tdata[4:0] !== oldest_date.day)
                    report_mismatch("day_out", int'(m_tdata[4:0]), int'(oldest_date.day));
                if (m_tdata[8:5] !== oldest_date.month)
                    report_mismatch("month_out", int'(m_tdata[8:5]), int'(oldest_date.month));
                if (m_tdata[22:9] !== oldest_date.year)
                    report_mismatch("year_out", int'(m_tdata[22:9]), int'(oldest_date.year));
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_calendar_edges();
        test_invalid_dates();
        test_drain_pause();
        test_random_dates(220);
        wait_results_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
